// File: hw/rtl/snr_pkg.sv
package snr_pkg;

  localparam int NUM_TERMS = 4;
  localparam int FRAC_BITS = 16;
  localparam int LOG_STAGES = 2 * FRAC_BITS;
  localparam int SNR_W = 24;

  // Configuration register indexes.
  localparam logic [2:0] REG_NOISE_SELECT = 3'd0;
  localparam logic [2:0] REG_EPS_FLOOR = 3'd1;
  localparam logic [2:0] REG_TERM_COUNT = 3'd2;
  localparam logic [2:0] REG_COEF_0 = 3'd3;
  localparam logic [2:0] REG_COEF_1 = 3'd4;
  localparam logic [2:0] REG_COEF_2 = 3'd5;
  localparam logic [2:0] REG_COEF_3 = 3'd6;

  // Noise source codes.
  localparam logic [1:0] MODE_RAW = 2'd0;
  localparam logic [1:0] MODE_MODEL = 2'd1;
  localparam logic [1:0] MODE_FLOOR = 2'd2;

  // Word carried from the noise select stage down the log2 pipeline.
  typedef struct packed {
    logic        ok;
    logic [30:0] signal;
    logic [30:0] noise;
    logic [31:0] base;
    logic        used;
    logic [31:0] raw;
  } snr_word_t;

  // Log2 unit iteration state for one operand.
  typedef struct packed {
    logic [4:0]           p;
    logic [32:0]          m;
    logic [FRAC_BITS-1:0] frac;
  } log_state_t;

endpackage

// File: hw/rtl/snr_log2_estimator_core.sv
// SNR log2 estimator. A word is taken whenever start is high and busy is
// low; busy is always low, so one word enters every cycle. Each word gives
// one result word on the result ports, marked by done for exactly one
// cycle, after passing through these registers in order: the lane
// products, the lane merge, noise selection and clamping, normalization,
// one squaring log2 step per fraction bit, and the output register. The
// receiver cannot stall the block. Configuration writes must only happen
// while no word is in flight.
module snr_log2_estimator_core
  import snr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output logic               done,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic signed [31:0] total_var,
  input  logic               total_finite,
  input  logic signed [31:0] raw_noise,
  input  logic               raw_finite,
  input  logic signed [31:0] feat_0,
  input  logic signed [31:0] feat_1,
  input  logic signed [31:0] feat_2,
  input  logic signed [31:0] feat_3,
  input  logic               feats_finite,
  output logic signed [23:0] snr_log2,
  output logic [30:0]        signal_var,
  output logic [30:0]        noise_var,
  output logic signed [31:0] baseline_var,
  output logic               baseline_used,
  output logic signed [31:0] raw_echo,
  output logic               result_valid
);

  logic [1:0]         noise_select;
  logic [30:0]        eps_floor;
  logic [2:0]         term_count;
  logic signed [31:0] coef [NUM_TERMS];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      noise_select <= MODE_FLOOR;
      eps_floor <= 31'd1;
      term_count <= 3'd1;
      for (int i = 0; i < NUM_TERMS; i++) coef[i] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NOISE_SELECT: noise_select <= cfg_data[1:0];
        REG_EPS_FLOOR: eps_floor <= cfg_data[30:0];
        REG_TERM_COUNT: term_count <= cfg_data[2:0];
        REG_COEF_0: coef[0] <= cfg_data;
        REG_COEF_1: coef[1] <= cfg_data;
        REG_COEF_2: coef[2] <= cfg_data;
        REG_COEF_3: coef[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic [1:0] mode;
  logic [2:0] nterm;
  assign mode = (noise_select == 2'd3) ? MODE_FLOOR : noise_select;
  assign nterm = (term_count == 3'd0) ? 3'd1 :
                 (term_count > 3'(NUM_TERMS)) ? 3'(NUM_TERMS) : term_count;

  logic signed [31:0] feat [NUM_TERMS];
  assign feat[0] = feat_0;
  assign feat[1] = feat_1;
  assign feat[2] = feat_2;
  assign feat[3] = feat_3;

  // Lanes.
  logic signed [63-FRAC_BITS:0] phi [NUM_TERMS];
  logic [FRAC_BITS-1:0]         plo [NUM_TERMS];
  for (genvar g = 0; g < NUM_TERMS; g++) begin : g_lane
    snr_lane u_lane (
      .clk(clk), .en(3'(g) < nterm), .coef(coef[g]), .feat(feat[g]),
      .prod_hi(phi[g]), .prod_lo(plo[g]));
  end

  // Stage 1 side data.
  logic               v1, tok1, rok1, fok1;
  logic [1:0]         mode1;
  logic signed [31:0] tot1, raw1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= start;
    tok1 <= total_finite;
    rok1 <= raw_finite;
    fok1 <= feats_finite;
    mode1 <= mode;
    tot1 <= total_var;
    raw1 <= raw_noise;
  end

  // Merge stage: sum of high parts plus carry out of the low parts.
  localparam int SW = 64 - FRAC_BITS + 3;
  logic signed [SW-1:0]  sum_hi;
  logic [FRAC_BITS+1:0]  sum_lo;
  always_comb begin
    sum_hi = '0;
    sum_lo = '0;
    for (int i = 0; i < NUM_TERMS; i++) begin
      sum_hi = sum_hi + SW'(phi[i]);
      sum_lo = sum_lo + (FRAC_BITS+2)'(plo[i]);
    end
  end

  logic               v2, tok2, rok2, fok2, bovf2;
  logic [1:0]         mode2;
  logic signed [31:0] tot2, raw2, base2;
  logic signed [SW-1:0] bsum;
  assign bsum = sum_hi + SW'(sum_lo[FRAC_BITS+1:FRAC_BITS]);
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else v2 <= v1;
    tok2 <= tok1;
    rok2 <= rok1;
    fok2 <= fok1;
    mode2 <= mode1;
    tot2 <= tot1;
    raw2 <= raw1;
    base2 <= bsum[31:0];
    bovf2 <= (bsum > SW'(32'sh7FFFFFFF)) || (bsum < -SW'(64'sh80000000));
  end

  // Noise selection, clamping and signal formation. A zero floor acts as one.
  logic signed [33:0] eps, noise_c, sig_c, sig_d;
  logic               need_base, ok;
  always_comb begin
    eps = (eps_floor == 31'd0) ? 34'sd1 : 34'(eps_floor);
    need_base = (mode2 != MODE_RAW);
    ok = tok2;
    if (mode2 == MODE_RAW && !rok2) ok = 1'b0;
    if (need_base && (!fok2 || bovf2)) ok = 1'b0;
    if (mode2 == MODE_RAW) noise_c = 34'(raw2);
    else if (mode2 == MODE_MODEL) noise_c = 34'(base2);
    else noise_c = (rok2 && raw2 > base2) ? 34'(raw2) : 34'(base2);
    if (noise_c < eps) noise_c = eps;
    sig_d = 34'(tot2) - noise_c;
    sig_c = sig_d;
    if (sig_c < eps) sig_c = eps;
    if (sig_c > 34'sh7FFFFFFF) sig_c = 34'sh7FFFFFFF;
  end

  logic      v3;
  snr_word_t w3;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else v3 <= v2;
    w3.ok <= ok;
    w3.signal <= sig_c[30:0];
    w3.noise <= noise_c[30:0];
    w3.base <= need_base ? base2 : 32'd0;
    w3.used <= need_base;
    w3.raw <= raw2;
  end

  // Normalization: leading one position and mantissa in Q1.31.
  function automatic log_state_t norm(input logic [30:0] x);
    log_state_t r;
    r.p = '0;
    for (int i = 0; i < 31; i++) if (x[i]) r.p = 5'(i);
    r.m = {2'b0, x} << (5'd31 - r.p);
    r.frac = '0;
    return r;
  endfunction

  logic       vs [FRAC_BITS+1];
  snr_word_t  ws [FRAC_BITS+1];
  log_state_t ss [FRAC_BITS+1];
  log_state_t ns [FRAC_BITS+1];
  always_ff @(posedge clk) begin
    if (rst) vs[0] <= 1'b0;
    else vs[0] <= v3;
    ws[0] <= w3;
    ss[0] <= norm(w3.signal);
    ns[0] <= norm(w3.noise);
  end

  for (genvar k = 0; k < FRAC_BITS; k++) begin : g_log
    snr_log_step u_step (
      .clk(clk), .rst(rst), .vin(vs[k]), .win(ws[k]), .sin(ss[k]), .nin(ns[k]),
      .vout(vs[k+1]), .wout(ws[k+1]), .sout(ss[k+1]), .nout(ns[k+1]));
  end

  // Difference of the two logs and output register.
  logic signed [FRAC_BITS+6:0] ls, ln, df;
  assign ls = {2'b0, ss[FRAC_BITS].p, ss[FRAC_BITS].frac};
  assign ln = {2'b0, ns[FRAC_BITS].p, ns[FRAC_BITS].frac};
  assign df = ls - ln;

  snr_word_t wf;
  assign wf = ws[FRAC_BITS];
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= vs[FRAC_BITS];
    result_valid <= wf.ok;
    snr_log2 <= wf.ok ? 24'(df) : '0;
    signal_var <= wf.ok ? wf.signal : '0;
    noise_var <= wf.ok ? wf.noise : '0;
    baseline_var <= wf.ok ? wf.base : '0;
    baseline_used <= wf.ok & wf.used;
    raw_echo <= wf.ok ? wf.raw : '0;
  end

endmodule

// File: hw/rtl/snr_lane.sv
// One baseline lane: registered product of a coefficient and a feature,
// split into its floor-shifted high part and its low fraction bits.
module snr_lane
  import snr_pkg::*;
(
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [31:0]          coef,
  input  logic signed [31:0]          feat,
  output logic signed [63-FRAC_BITS:0] prod_hi,
  output logic [FRAC_BITS-1:0]        prod_lo
);

  logic signed [63:0] prod;

  // Arithmetic shift gives the floor-rounded high part directly.
  always_ff @(posedge clk) begin
    prod <= en ? coef * feat : 64'sd0;
  end

  assign prod_hi = prod[63:FRAC_BITS];
  assign prod_lo = prod[FRAC_BITS-1:0];

endmodule

// File: hw/rtl/snr_log_step.sv
// One fraction bit of the squaring log2 for the signal and noise operands.
module snr_log_step
  import snr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       vin,
  input  snr_word_t  win,
  input  log_state_t sin,
  input  log_state_t nin,
  output logic       vout,
  output snr_word_t  wout,
  output log_state_t sout,
  output log_state_t nout
);

  function automatic log_state_t step(input log_state_t s);
    logic [65:0] sq;
    log_state_t  r;
    sq = s.m * s.m;
    r = s;
    r.m = sq[63:31];
    r.frac = {s.frac[FRAC_BITS-2:0], 1'b0};
    if (sq[63]) begin
      r.frac[0] = 1'b1;
      r.m = {1'b0, sq[63:32]};
    end
    return r;
  endfunction

  // Square, test and halve; one register after each squaring.
  always_ff @(posedge clk) begin
    if (rst) vout <= 1'b0;
    else vout <= vin;
    wout <= win;
    sout <= step(sin);
    nout <= step(nin);
  end

endmodule

// File: tb/tb_snr_log2_estimator_core.sv
module tb_snr_log2_estimator_core;
  import snr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Index past the end of the register list; writes to it must be ignored.
  localparam logic [2:0] REG_UNUSED = 3'd7;

  typedef struct {
    logic signed [31:0] total;
    logic               total_ok;
    logic signed [31:0] raw;
    logic               raw_ok;
    logic signed [31:0] feat [4];
    logic               feats_ok;
  } snr_in_t;

  typedef struct {
    logic signed [23:0] snr;
    logic [30:0]        signal;
    logic [30:0]        noise;
    logic signed [31:0] base;
    logic               used;
    logic signed [31:0] raw;
    logic               ok;
  } snr_out_t;

  // Holds the register copy, predicts each word and checks results in order.
  class snr_scoreboard;
    logic [1:0]         sel = MODE_FLOOR;
    logic [30:0]        eps = 31'd1;
    logic [2:0]         terms = 3'd1;
    logic signed [31:0] coef [4] = '{0, 0, 0, 0};
    snr_out_t           pending [$];
    int                 errors = 0;

    function void write_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        REG_NOISE_SELECT: sel = data[1:0];
        REG_EPS_FLOOR:    eps = data[30:0];
        REG_TERM_COUNT:   terms = data[2:0];
        REG_COEF_0:       coef[0] = data;
        REG_COEF_1:       coef[1] = data;
        REG_COEF_2:       coef[2] = data;
        REG_COEF_3:       coef[3] = data;
        default: ;
      endcase
    endfunction

    // Integer part is the top set bit; fraction bits come from repeated squaring.
    function longint log2_q(logic [31:0] x);
      int unsigned p;
      logic [63:0] m;
      longint      frac;
      p = 0;
      frac = 0;
      if (x == 0) return 0;
      while (p < 31 && (x >> (p + 1)) != 0) p++;
      m = 64'(x) << (31 - p);
      for (int i = 0; i < FRAC_BITS; i++) begin
        m = (m * m) >> 31;
        frac = frac << 1;
        if (m >= 64'h1_0000_0000) begin
          frac = frac | 1;
          m = m >> 1;
        end
      end
      return longint'(p) * (longint'(1) << FRAC_BITS) + frac;
    endfunction

    function snr_out_t estimate(snr_in_t w);
      snr_out_t r;
      logic [1:0] mode;
      bit need, ok;
      longint lim, base, noise, signal, snr, hi, lo, prod;
      int n;
      mode = (sel == 2'd3) ? MODE_FLOOR : sel;
      need = (mode != MODE_RAW);
      ok = w.total_ok;
      lim = (eps == 0) ? 1 : longint'(eps);
      base = 0;
      if (mode == MODE_RAW && !w.raw_ok) ok = 0;
      // Baseline is the floored dot product over the active terms.
      if (ok && need) begin
        n = (terms == 0) ? 1 : terms;
        if (n > NUM_TERMS) n = NUM_TERMS;
        if (!w.feats_ok) ok = 0;
        hi = 0;
        lo = 0;
        for (int i = 0; i < n; i++) begin
          prod = longint'(coef[i]) * longint'(w.feat[i]);
          hi += prod >>> FRAC_BITS;
          lo += prod & 64'hFFFF;
        end
        base = hi + (lo >>> FRAC_BITS);
        if (base > 64'sd2147483647 || base < -64'sd2147483648) ok = 0;
      end
      r = '{snr: 0, signal: 0, noise: 0, base: 0, used: 0, raw: 0, ok: 0};
      if (ok) begin
        if (mode == MODE_RAW) noise = w.raw;
        else if (mode == MODE_MODEL) noise = base;
        else noise = (w.raw_ok && longint'(w.raw) > base) ? longint'(w.raw) : base;
        if (noise < lim) noise = lim;
        signal = longint'(w.total) - noise;
        if (signal < lim) signal = lim;
        if (signal > 64'sd2147483647) signal = 64'sd2147483647;
        snr = log2_q(signal[31:0]) - log2_q(noise[31:0]);
        if (snr > 64'sd8388607) snr = 64'sd8388607;
        if (snr < -64'sd8388608) snr = -64'sd8388608;
        r.snr = snr[23:0];
        r.signal = signal[30:0];
        r.noise = noise[30:0];
        r.base = need ? base[31:0] : 32'd0;
        r.used = need;
        r.raw = w.raw;
        r.ok = 1'b1;
      end
      return r;
    endfunction

    function void note_word(snr_in_t w);
      pending.push_back(estimate(w));
    endfunction

    function void check_word(snr_out_t got);
      snr_out_t e;
      if (pending.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.snr !== e.snr) begin
        $error("snr_log2 expected %0d got %0d", e.snr, got.snr); errors++;
      end
      if (got.signal !== e.signal) begin
        $error("signal_var expected %0d got %0d", e.signal, got.signal); errors++;
      end
      if (got.noise !== e.noise) begin
        $error("noise_var expected %0d got %0d", e.noise, got.noise); errors++;
      end
      if (got.base !== e.base) begin
        $error("baseline_var expected %0d got %0d", e.base, got.base); errors++;
      end
      if (got.used !== e.used) begin
        $error("baseline_used expected %0d got %0d", e.used, got.used); errors++;
      end
      if (got.raw !== e.raw) begin
        $error("raw_echo expected %0d got %0d", e.raw, got.raw); errors++;
      end
      if (got.ok !== e.ok) begin
        $error("result_valid expected %0d got %0d", e.ok, got.ok); errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic start, busy, done;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;
  logic signed [31:0] total_var, raw_noise, feat_0, feat_1, feat_2, feat_3;
  logic total_finite, raw_finite, feats_finite;
  logic signed [23:0] snr_log2;
  logic [30:0] signal_var, noise_var;
  logic signed [31:0] baseline_var, raw_echo;
  logic baseline_used, result_valid;

  snr_scoreboard sb = new();
  int idle_pct;

  snr_log2_estimator_core uut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Results cannot be held off, so every strobed word is checked on the spot.
  always @(posedge clk) begin
    if (!rst && done)
      sb.check_word('{snr: snr_log2, signal: signal_var, noise: noise_var,
                      base: baseline_var, used: baseline_used, raw: raw_echo,
                      ok: result_valid});
  end

  initial begin
    #2ms;
    $display("tb_snr_log2_estimator_core NOT OK");
    $finish;
  end

  // Mix of full range, small Q16.16 magnitudes and extremes.
  function logic signed [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 32'h0100_0000);
      2: return int'($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
      3: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return $urandom_range(0, 32'h0010_0000);
    endcase
  endfunction

  function snr_in_t pick_word();
    snr_in_t w;
    w.total = pick_value();
    w.raw = pick_value();
    foreach (w.feat[i]) w.feat[i] = pick_value();
    if ($urandom_range(0, 3) == 0) w.feat[0] = 32'sh0001_0000;
    w.total_ok = ($urandom_range(0, 9) != 0);
    w.raw_ok = ($urandom_range(0, 9) != 0);
    w.feats_ok = ($urandom_range(0, 9) != 0);
    return w;
  endfunction

  // Called just after the clock rises; returns once the block has taken the word.
  task automatic send_word(snr_in_t w);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    total_var <= w.total;
    total_finite <= w.total_ok;
    raw_noise <= w.raw;
    raw_finite <= w.raw_ok;
    feat_0 <= w.feat[0];
    feat_1 <= w.feat[1];
    feat_2 <= w.feat[2];
    feat_3 <= w.feat[3];
    feats_finite <= w.feats_ok;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_word(w);
  endtask

  // Stop sending and hold until every expected word has come back.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  function logic [31:0] pick_coef();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return int'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
    endcase
  endfunction

  task automatic setup(int k);
    logic [31:0] e;
    case (k)
      0: begin
        write_reg(REG_NOISE_SELECT, 32'(MODE_RAW));
        write_reg(REG_EPS_FLOOR, 32'd0);
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
      end
      1: begin
        write_reg(REG_NOISE_SELECT, 32'(MODE_MODEL));
        write_reg(REG_EPS_FLOOR, 32'h7FFF_FFFF);
        write_reg(REG_TERM_COUNT, 32'd7);
        write_reg(REG_COEF_0, 32'h7FFF_FFFF);
        write_reg(REG_COEF_1, 32'h7FFF_FFFF);
        write_reg(REG_COEF_2, 32'h7FFF_FFFF);
        write_reg(REG_COEF_3, 32'h7FFF_FFFF);
      end
      2: begin
        write_reg(REG_NOISE_SELECT, 32'd3);
        write_reg(REG_EPS_FLOOR, 32'hFFFF_FFFF);
        write_reg(REG_TERM_COUNT, 32'd0);
        write_reg(REG_COEF_0, 32'h8000_0000);
        write_reg(REG_COEF_1, 32'h8000_0000);
        write_reg(REG_COEF_2, 32'h8000_0000);
        write_reg(REG_COEF_3, 32'h8000_0000);
      end
      default: begin
        case ($urandom_range(0, 3))
          0: e = 32'd1;
          1: e = $urandom();
          default: e = $urandom_range(1, 32'h0001_0000);
        endcase
        write_reg(REG_NOISE_SELECT, $urandom_range(0, 3));
        write_reg(REG_EPS_FLOOR, e);
        write_reg(REG_TERM_COUNT, $urandom_range(0, 7));
        write_reg(REG_COEF_0, pick_coef());
        write_reg(REG_COEF_1, pick_coef());
        write_reg(REG_COEF_2, pick_coef());
        write_reg(REG_COEF_3, pick_coef());
      end
    endcase
    cfg_we <= 1'b0;
  endtask

  initial begin
    snr_in_t w;
    rst <= 1'b1;
    start <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    total_var <= '0;
    total_finite <= 1'b0;
    raw_noise <= '0;
    raw_finite <= 1'b0;
    feat_0 <= '0;
    feat_1 <= '0;
    feat_2 <= '0;
    feat_3 <= '0;
    feats_finite <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words on the reset settings: field extremes and each finite flag cleared in turn.
    idle_pct = 0;
    for (int k = 0; k < 12; k++) begin
      w.total = (k % 3 == 0) ? 32'sh7FFF_FFFF : (k % 3 == 1) ? 32'sh8000_0000 : 32'sh0010_0000;
      w.raw = (k % 4 == 0) ? 32'sh8000_0000 : (k % 4 == 1) ? 32'sh7FFF_FFFF :
              (k % 4 == 2) ? 32'sh0 : 32'sh0000_8000;
      w.feat = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'shFFFF_FFFF, 32'sh0001_0000};
      w.total_ok = (k != 4);
      w.raw_ok = (k != 5) && (k != 9);
      w.feats_ok = (k != 6);
      send_word(w);
    end
    drain();

    // Random phases, each on its own settings with a few directed words up front.
    for (int ph = 0; ph < 7; ph++) begin
      setup(ph);
      @(posedge clk);
      idle_pct = (ph < 3) ? 14 : (ph < 5) ? 73 : 0;
      for (int k = 0; k < 4; k++) begin
        w = pick_word();
        w.total_ok = 1'b1;
        w.raw_ok = (k != 0);
        w.feats_ok = (k != 1);
        send_word(w);
      end
      for (int k = 0; k < 245; k++) send_word(pick_word());
      drain();
    end

    repeat (30) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("tb_snr_log2_estimator_core OK");
    else
      $display("tb_snr_log2_estimator_core NOT OK");
    $finish;
  end

endmodule
